// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the status LED pattern generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

// ===== rtl/core/slpg_pkg.sv =====
// Types, codes and the raised-cosine table of the status LED pattern generator.
package slpg_pkg;

  localparam int TIME_W  = 32;
  localparam int LEVEL_W = 8;
  localparam int MODE_W  = 4;
  localparam int PER_W   = 16;
  localparam int RC_W    = 17;
  localparam int RC_DIF_W = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Requested display modes.
  localparam logic [MODE_W-1:0] MODE_OFF         = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SOLID_GREEN = 4'd1;
  localparam logic [MODE_W-1:0] MODE_SOLID_AMBER = 4'd2;
  localparam logic [MODE_W-1:0] MODE_SLOW_AMBER  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_FAST_AMBER  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_RED_BLINK   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_AMBER_PULSE = 4'd6;
  localparam logic [MODE_W-1:0] MODE_GREEN_FLASH = 4'd7;
  localparam logic [MODE_W-1:0] MODE_RED_FLASH   = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_DUTY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX    = 3'd5;

  // Blink intervals in milliseconds.
  localparam logic [TIME_W-1:0] SLOW_MS  = 32'd500;
  localparam logic [TIME_W-1:0] FAST_MS  = 32'd180;
  localparam logic [TIME_W-1:0] FLASH_MS = 32'd120;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] yellow_level;
    logic [LEVEL_W-1:0] green_level;
  } out_word_t;

  // Raised cosine sin^2 over a half period in 16 segments, 65536 meaning one.
  function automatic logic [RC_W-1:0] rc_tab(input logic [4:0] k);
    logic [RC_W-1:0] v;
    case (k)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd630;
      5'd2:    v = 17'd2494;
      5'd3:    v = 17'd5522;
      5'd4:    v = 17'd9597;
      5'd5:    v = 17'd14563;
      5'd6:    v = 17'd20228;
      5'd7:    v = 17'd26375;
      5'd8:    v = 17'd32768;
      5'd9:    v = 17'd39161;
      5'd10:   v = 17'd45308;
      5'd11:   v = 17'd50973;
      5'd12:   v = 17'd55939;
      5'd13:   v = 17'd60014;
      5'd14:   v = 17'd63042;
      5'd15:   v = 17'd64906;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/status_led_pattern_generator.sv =====
// Top level of the status LED pattern generator: mode sequencer and breathing datapath.
//
//   channel | ports                          | direction | word
//   input   | in_valid, in_ready, in_data    | in        | slpg_pkg::in_word_t
//   result  | out_valid, out_ready, out_data | out       | slpg_pkg::out_word_t
//   config  | cfg_we, cfg_idx, cfg_wdata     | in        | register index and value
//
// A word in any mode but amber breathing passes the evaluate and finish states
// before its result is registered. Amber breathing runs evaluate, the restoring
// divider (one bit per cycle, forming the phase), interpolate, scale and finish.
// One word is in work at a time; in_ready returns once the result is registered.
// A result stalled on out_ready holds the finished word; reset is synchronous.
`include "assert_macros.svh"

module status_led_pattern_generator #(
  parameter int PHASE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  slpg_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output slpg_pkg::out_word_t                 out_data,
  input  logic                                cfg_we,
  input  logic [slpg_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [slpg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int STEPS = slpg_pkg::TIME_W + PHASE_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int PROD_W = slpg_pkg::RC_DIF_W + PHASE_BITS - 1;
  localparam int SPROD_W = slpg_pkg::LEVEL_W + slpg_pkg::RC_W;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_DIV, S_INTERP, S_SCALE, S_FINISH
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [slpg_pkg::LEVEL_W-1:0] full_level_r, off_level_r, green_duty_r;
  logic [slpg_pkg::LEVEL_W-1:0] pulse_min_r, pulse_max_r;
  logic [slpg_pkg::PER_W-1:0]   pulse_period_r;

  // Pattern state and work registers.
  logic [slpg_pkg::MODE_W-1:0]  active_mode_r;
  logic [slpg_pkg::TIME_W-1:0]  last_toggle_r;
  logic                         blink_lit_r;
  logic [slpg_pkg::TIME_W-1:0]  now_r;
  logic [slpg_pkg::TIME_W-1:0]  div_r;
  logic [slpg_pkg::PER_W-1:0]   rem_r;
  logic [PHASE_BITS-1:0]        idx_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [slpg_pkg::RC_W-1:0]    rc_r;
  slpg_pkg::out_word_t          res_r;
  slpg_pkg::out_word_t          out_data_r;
  logic                         out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_level_r   <= 8'd255;
      off_level_r    <= 8'd0;
      green_duty_r   <= 8'd128;
      pulse_period_r <= 16'd2000;
      pulse_min_r    <= 8'd10;
      pulse_max_r    <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        slpg_pkg::CFG_FULL_LEVEL:   full_level_r   <= cfg_wdata[slpg_pkg::LEVEL_W-1:0];
        slpg_pkg::CFG_OFF_LEVEL:    off_level_r    <= cfg_wdata[slpg_pkg::LEVEL_W-1:0];
        slpg_pkg::CFG_GREEN_DUTY:   green_duty_r   <= cfg_wdata[slpg_pkg::LEVEL_W-1:0];
        slpg_pkg::CFG_PULSE_PERIOD: pulse_period_r <= cfg_wdata;
        slpg_pkg::CFG_PULSE_MIN:    pulse_min_r    <= cfg_wdata[slpg_pkg::LEVEL_W-1:0];
        slpg_pkg::CFG_PULSE_MAX:    pulse_max_r    <= cfg_wdata[slpg_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero period behaves as one.
  logic [slpg_pkg::PER_W-1:0] per;
  assign per = (pulse_period_r == '0) ? 16'd1 : pulse_period_r;

  // One restoring divider step on {now, PHASE_BITS zeros}; the last PHASE_BITS
  // quotient bits are the phase index.
  logic [slpg_pkg::PER_W:0] trial, trial_sub;
  logic                     trial_ge;
  assign trial     = {rem_r, div_r[slpg_pkg::TIME_W-1]};
  assign trial_sub = trial - {1'b0, per};
  assign trial_ge  = trial >= {1'b0, per};

  // Fold the phase into a half wave and interpolate the table.
  logic [PHASE_BITS-1:0]         h;
  logic [4:0]                    seg;
  logic [PHASE_BITS-2:0]         frac;
  logic [slpg_pkg::RC_W-1:0]     t0, t1;
  logic [slpg_pkg::RC_DIF_W-1:0] dif;
  logic [PROD_W-1:0]             prod;
  assign h    = idx_r[PHASE_BITS-1] ? PHASE_BITS'(-idx_r) : idx_r;
  assign seg  = h[PHASE_BITS-1 -: 5];
  assign frac = {h[PHASE_BITS-6:0], 4'b0000};
  assign t0   = slpg_pkg::rc_tab(seg);
  assign t1   = slpg_pkg::rc_tab(5'(seg + 5'd1));
  assign dif  = slpg_pkg::RC_DIF_W'(t1 - t0);
  assign prod = PROD_W'(dif * frac);

  // Scale the raised cosine into the level span.
  logic [slpg_pkg::LEVEL_W-1:0] span;
  logic [SPROD_W-1:0]           sprod;
  assign span  = (pulse_max_r > pulse_min_r) ? pulse_max_r - pulse_min_r : '0;
  assign sprod = SPROD_W'(span * rc_r);

  // Blink decision for the active mode.
  logic                         is_blink;
  logic [slpg_pkg::TIME_W-1:0]  interval;
  logic [slpg_pkg::TIME_W-1:0]  elapsed;
  logic                         toggle;
  logic                         lit_new;
  logic [slpg_pkg::LEVEL_W-1:0] green_on;
  slpg_pkg::out_word_t          eval_res;

  always_comb begin
    is_blink = 1'b1;
    unique case (active_mode_r) inside
      slpg_pkg::MODE_SLOW_AMBER:                             interval = slpg_pkg::SLOW_MS;
      slpg_pkg::MODE_FAST_AMBER, slpg_pkg::MODE_RED_BLINK:   interval = slpg_pkg::FAST_MS;
      slpg_pkg::MODE_GREEN_FLASH, slpg_pkg::MODE_RED_FLASH:  interval = slpg_pkg::FLASH_MS;
      default: begin
        interval = slpg_pkg::SLOW_MS;
        is_blink = 1'b0;
      end
    endcase
  end

  assign elapsed  = now_r - last_toggle_r;
  assign toggle   = is_blink && (elapsed >= interval);
  assign lit_new  = blink_lit_r ^ toggle;
  assign green_on = (full_level_r > green_duty_r) ? full_level_r - green_duty_r : '0;

  always_comb begin
    eval_res.red_level    = off_level_r;
    eval_res.yellow_level = off_level_r;
    eval_res.green_level  = full_level_r;
    unique case (active_mode_r) inside
      slpg_pkg::MODE_SOLID_GREEN: eval_res.green_level = green_on;
      slpg_pkg::MODE_SOLID_AMBER: eval_res.yellow_level = full_level_r;
      slpg_pkg::MODE_SLOW_AMBER, slpg_pkg::MODE_FAST_AMBER: begin
        if (lit_new) eval_res.yellow_level = full_level_r;
      end
      slpg_pkg::MODE_RED_BLINK, slpg_pkg::MODE_RED_FLASH: begin
        if (lit_new) eval_res.red_level = full_level_r;
      end
      slpg_pkg::MODE_GREEN_FLASH: begin
        if (lit_new) eval_res.green_level = green_on;
      end
      default: ;
    endcase
  end

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      active_mode_r <= slpg_pkg::MODE_OFF;
      last_toggle_r <= '0;
      blink_lit_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      cnt_r         <= '0;
    end else begin
      // The finish state reloads the output register itself.
      if (out_valid_r && out_ready && state_r != S_FINISH) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            now_r <= in_data.now_ms;
            if (in_data.mode != active_mode_r) begin
              active_mode_r <= in_data.mode;
              last_toggle_r <= in_data.now_ms;
              blink_lit_r   <= 1'b0;
            end
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (active_mode_r == slpg_pkg::MODE_AMBER_PULSE) begin
            res_r.red_level   <= off_level_r;
            res_r.green_level <= full_level_r;
            div_r   <= now_r;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end else begin
            if (toggle) begin
              blink_lit_r   <= lit_new;
              last_toggle_r <= now_r;
            end
            res_r   <= eval_res;
            state_r <= S_FINISH;
          end
        end
        S_DIV: begin
          rem_r <= trial_ge ? trial_sub[slpg_pkg::PER_W-1:0] : trial[slpg_pkg::PER_W-1:0];
          div_r <= {div_r[slpg_pkg::TIME_W-2:0], 1'b0};
          idx_r <= {idx_r[PHASE_BITS-2:0], trial_ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(STEPS - 1)) state_r <= S_INTERP;
        end
        S_INTERP: begin
          // The top of the half wave sits exactly on the last table entry.
          if (seg[4]) rc_r <= t0;
          else rc_r <= t0 + slpg_pkg::RC_W'(prod >> (PHASE_BITS - 1));
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          res_r.yellow_level <= pulse_min_r + slpg_pkg::LEVEL_W'(sprod >> 16);
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `ASSERT_SAME(a_rem_below_period, state_r == S_DIV, {1'b0, rem_r} < {1'b0, per})
  `ASSERT_NEXT(a_finish_delivers, state_r == S_FINISH && out_free, out_valid_r && in_ready)
  `ASSERT_SAME(a_lit_only_in_blink, blink_lit_r,
               active_mode_r == slpg_pkg::MODE_SLOW_AMBER ||
               active_mode_r == slpg_pkg::MODE_FAST_AMBER ||
               active_mode_r == slpg_pkg::MODE_RED_BLINK ||
               active_mode_r == slpg_pkg::MODE_GREEN_FLASH ||
               active_mode_r == slpg_pkg::MODE_RED_FLASH)

endmodule
